[sv/pes_pkg.sv]
// Shared types, codes and default sizes for the periodic event scheduler.
// No dependencies; every other file of the block refers to this package.
package pes_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int TIME_BITS_DEF   = 48;
  localparam int HANDLE_BITS_DEF = 16;

  // Fixed port field widths
  localparam int REQ_W    = 2;
  localparam int HANDLE_W = 16;
  localparam int PERIOD_W = 32;
  localparam int TIME_W   = 48;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int STAMP_W  = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIRE   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_DUP     = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOT_DUE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_APPLY,
    ST_SCAN2,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    WR_ADD,
    WR_CLEAR,
    WR_FIRE
  } wr_op_t;

  // Flags that ride along with the probe through the cell row
  typedef struct packed {
    logic valid;
    logic found;
    logic has_free;
    logic has_best;
  } chain_flags_t;

  // Slot write command broadcast to all cells
  typedef struct packed {
    logic   en;
    wr_op_t op;
  } wr_ctl_t;

endpackage

[sv/pes_in_if.sv]
// Request channel of the periodic event scheduler.
// Depends on pes_pkg for field widths.
interface pes_in_if;
  logic                         valid;
  logic                         ready;
  logic [pes_pkg::REQ_W-1:0]    req_type;
  logic [pes_pkg::HANDLE_W-1:0] event_handle;
  logic [pes_pkg::PERIOD_W-1:0] period_ticks;
  logic [pes_pkg::TIME_W-1:0]   start_time;
  logic [pes_pkg::TIME_W-1:0]   now_time;

  modport source (output valid, req_type, event_handle, period_ticks, start_time, now_time,
                  input ready);
  modport sink (input valid, req_type, event_handle, period_ticks, start_time, now_time,
                output ready);
  modport mon (input valid, ready, req_type, event_handle, period_ticks, start_time,
               now_time);
endinterface

[sv/pes_out_if.sv]
// Result channel of the periodic event scheduler.
// Depends on pes_pkg for field widths.
interface pes_out_if;
  logic                         valid;
  logic                         ready;
  logic [pes_pkg::STATUS_W-1:0] status;
  logic [pes_pkg::HANDLE_W-1:0] due_handle;
  logic [pes_pkg::TIME_W-1:0]   next_due_time;
  logic [pes_pkg::COUNT_W-1:0]  live_count;

  modport source (output valid, status, due_handle, next_due_time, live_count,
                  input ready);
  modport sink (input valid, status, due_handle, next_due_time, live_count,
                output ready);
  modport mon (input valid, ready, status, due_handle, next_due_time, live_count);
endinterface

[sv/pes_cell.sv]
// One slot of the event table plus its stage of the scan probe.
// Depends on pes_pkg for the probe flags and write command types.
module pes_cell #(
  parameter int SLOTS       = pes_pkg::SLOTS_DEF,
  parameter int TIME_BITS   = pes_pkg::TIME_BITS_DEF,
  parameter int HANDLE_BITS = pes_pkg::HANDLE_BITS_DEF,
  parameter int IDX         = 0,
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CNT_W      = $clog2(SLOTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  // broadcast
  input  logic [HANDLE_BITS-1:0]       key,
  input  logic [pes_pkg::STAMP_W-1:0]  counter,
  input  pes_pkg::wr_ctl_t             wr_ctl,
  input  logic [IDX_W-1:0]             wr_idx,
  input  logic [HANDLE_BITS-1:0]       wr_handle,
  input  logic [pes_pkg::PERIOD_W-1:0] wr_period,
  input  logic [TIME_BITS-1:0]         wr_due,
  input  logic [pes_pkg::STAMP_W-1:0]  wr_stamp,
  // probe from the left neighbor
  input  pes_pkg::chain_flags_t        in_flags,
  input  logic [IDX_W-1:0]             in_found_idx,
  input  logic [IDX_W-1:0]             in_free_idx,
  input  logic [IDX_W-1:0]             in_best_idx,
  input  logic [TIME_BITS-1:0]         in_best_due,
  input  logic [pes_pkg::STAMP_W-1:0]  in_best_age,
  input  logic [HANDLE_BITS-1:0]       in_best_handle,
  input  logic [pes_pkg::PERIOD_W-1:0] in_best_period,
  input  logic [CNT_W-1:0]             in_count,
  // probe to the right neighbor
  output pes_pkg::chain_flags_t        out_flags,
  output logic [IDX_W-1:0]             out_found_idx,
  output logic [IDX_W-1:0]             out_free_idx,
  output logic [IDX_W-1:0]             out_best_idx,
  output logic [TIME_BITS-1:0]         out_best_due,
  output logic [pes_pkg::STAMP_W-1:0]  out_best_age,
  output logic [HANDLE_BITS-1:0]       out_best_handle,
  output logic [pes_pkg::PERIOD_W-1:0] out_best_period,
  output logic [CNT_W-1:0]             out_count
);

  logic                         live;
  logic [HANDLE_BITS-1:0]       handle;
  logic [pes_pkg::PERIOD_W-1:0] period;
  logic [TIME_BITS-1:0]         due;
  logic [pes_pkg::STAMP_W-1:0]  stamp;

  logic                         sel;
  logic                         hit;
  logic                         take;
  logic [pes_pkg::STAMP_W-1:0]  age;

  // Decode this cell's write and evaluate the probe
  always_comb begin
    sel  = wr_ctl.en && (wr_idx == IDX_W'(IDX));
    age  = counter - stamp;
    hit  = live && (handle == key);
    take = live && (!in_flags.has_best || (due < in_best_due) ||
                    ((due == in_best_due) && (age > in_best_age)));
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (sel) begin
      case (wr_ctl.op)
        pes_pkg::WR_ADD:   live <= 1'b1;
        pes_pkg::WR_CLEAR: live <= 1'b0;
        default:           live <= live;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && (wr_ctl.op == pes_pkg::WR_ADD)) begin
      handle <= wr_handle;
      period <= wr_period;
    end
    if (sel && ((wr_ctl.op == pes_pkg::WR_ADD) || (wr_ctl.op == pes_pkg::WR_FIRE))) begin
      due   <= wr_due;
      stamp <= wr_stamp;
    end
  end

  // Probe stage: hand the updated probe to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      out_flags <= '0;
    end else begin
      out_flags.valid    <= in_flags.valid;
      out_flags.found    <= in_flags.found || hit;
      out_flags.has_free <= in_flags.has_free || !live;
      out_flags.has_best <= in_flags.has_best || take;
    end
  end

  always_ff @(posedge clk) begin
    out_found_idx   <= (!in_flags.found && hit) ? IDX_W'(IDX) : in_found_idx;
    out_free_idx    <= (!in_flags.has_free && !live) ? IDX_W'(IDX) : in_free_idx;
    out_best_idx    <= take ? IDX_W'(IDX) : in_best_idx;
    out_best_due    <= take ? due : in_best_due;
    out_best_age    <= take ? age : in_best_age;
    out_best_handle <= take ? handle : in_best_handle;
    out_best_period <= take ? period : in_best_period;
    out_count       <= in_count + CNT_W'(live);
  end

endmodule

[sv/periodic_event_scheduler.sv]
// Top level of the periodic event scheduler: request control and the cell row.
// Depends on pes_pkg, pes_in_if, pes_out_if and pes_cell.

// Each request passes from its transfer to its result through a probe that walks
// the row of SLOTS cells one cell a cycle to find the handle, a free slot and the
// earliest due event, an apply step that writes the change, and a second walk that
// collects the earliest due time and live count for the result. One request is in
// work at a time; a finished result waits in the output register while the next
// request is taken in.
module periodic_event_scheduler #(
  parameter int SLOTS       = pes_pkg::SLOTS_DEF,
  parameter int TIME_BITS   = pes_pkg::TIME_BITS_DEF,
  parameter int HANDLE_BITS = pes_pkg::HANDLE_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  pes_in_if.sink   in_ch,
  pes_out_if.source out_ch
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SUM_W = ((TIME_BITS > pes_pkg::PERIOD_W) ? TIME_BITS : pes_pkg::PERIOD_W) + 1;

  pes_pkg::state_t state, state_next;

  // Latched request
  pes_pkg::req_t                kind;
  logic [HANDLE_BITS-1:0]       key;
  logic [pes_pkg::PERIOD_W-1:0] period;
  logic [TIME_BITS-1:0]         start;
  logic [TIME_BITS-1:0]         now;
  logic [pes_pkg::STAMP_W-1:0]  counter;

  // First pass results
  pes_pkg::chain_flags_t        p_flags;
  logic [IDX_W-1:0]             p_found_idx;
  logic [IDX_W-1:0]             p_free_idx;
  logic [IDX_W-1:0]             p_best_idx;
  logic [TIME_BITS-1:0]         p_best_due;
  logic [HANDLE_BITS-1:0]       p_best_handle;
  logic [pes_pkg::PERIOD_W-1:0] p_best_period;

  pes_pkg::status_t             status_r;
  logic [HANDLE_BITS-1:0]       fired;
  logic                         r_has_best;
  logic [TIME_BITS-1:0]         r_due;
  logic [CNT_W-1:0]             r_count;

  logic                         probe_start;
  logic                         accept;
  logic                         start_set;
  logic                         load_p1;
  logic                         load_p2;
  logic                         load_out;
  logic                         apply;

  pes_pkg::wr_ctl_t             wr_ctl;
  logic [IDX_W-1:0]             wr_idx;
  logic [TIME_BITS-1:0]         wr_due;
  pes_pkg::status_t             status_next;
  logic                         bump;

  logic [SUM_W-1:0]             sum;
  logic [TIME_BITS-1:0]         sat;
  logic [TIME_BITS-1:0]         fire_due;
  logic                         is_due;

  // Probe chain between cells
  pes_pkg::chain_flags_t        c_flags  [SLOTS+1];
  logic [IDX_W-1:0]             c_found  [SLOTS+1];
  logic [IDX_W-1:0]             c_free   [SLOTS+1];
  logic [IDX_W-1:0]             c_bidx   [SLOTS+1];
  logic [TIME_BITS-1:0]         c_bdue   [SLOTS+1];
  logic [pes_pkg::STAMP_W-1:0]  c_bage   [SLOTS+1];
  logic [HANDLE_BITS-1:0]       c_bhandle[SLOTS+1];
  logic [pes_pkg::PERIOD_W-1:0] c_bperiod[SLOTS+1];
  logic [CNT_W-1:0]             c_count  [SLOTS+1];

  // Feed an empty probe into the head of the row
  always_comb begin
    c_flags[0]       = '{valid: probe_start, found: 1'b0, has_free: 1'b0, has_best: 1'b0};
    c_found[0]       = '0;
    c_free[0]        = '0;
    c_bidx[0]        = '0;
    c_bdue[0]        = '0;
    c_bage[0]        = '0;
    c_bhandle[0]     = '0;
    c_bperiod[0]     = '0;
    c_count[0]       = '0;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    pes_cell #(
      .SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .HANDLE_BITS(HANDLE_BITS), .IDX(i)
    ) u_cell (
      .clk(clk), .rst(rst),
      .key(key), .counter(counter),
      .wr_ctl(wr_ctl), .wr_idx(wr_idx),
      .wr_handle(key), .wr_period(period), .wr_due(wr_due), .wr_stamp(counter),
      .in_flags(c_flags[i]), .in_found_idx(c_found[i]), .in_free_idx(c_free[i]),
      .in_best_idx(c_bidx[i]), .in_best_due(c_bdue[i]), .in_best_age(c_bage[i]),
      .in_best_handle(c_bhandle[i]), .in_best_period(c_bperiod[i]),
      .in_count(c_count[i]),
      .out_flags(c_flags[i+1]), .out_found_idx(c_found[i+1]), .out_free_idx(c_free[i+1]),
      .out_best_idx(c_bidx[i+1]), .out_best_due(c_bdue[i+1]), .out_best_age(c_bage[i+1]),
      .out_best_handle(c_bhandle[i+1]), .out_best_period(c_bperiod[i+1]),
      .out_count(c_count[i+1])
    );
  end

  // Next due time of a fired event: saturate, then never behind now
  always_comb begin
    sum      = SUM_W'(p_best_due) + SUM_W'(p_best_period);
    sat      = (sum > SUM_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}} : TIME_BITS'(sum);
    fire_due = (sat < now) ? now : sat;
    is_due   = p_flags.has_best && (now >= p_best_due);
  end

  // Decide the slot write and status of the request
  always_comb begin
    wr_ctl      = '{en: 1'b0, op: pes_pkg::WR_ADD};
    wr_idx      = p_free_idx;
    wr_due      = start;
    status_next = pes_pkg::STAT_OK;
    bump        = 1'b0;
    case (kind)
      pes_pkg::REQ_ADD: begin
        if (p_flags.found) begin
          status_next = pes_pkg::STAT_DUP;
        end else if (!p_flags.has_free) begin
          status_next = pes_pkg::STAT_FULL;
        end else begin
          wr_ctl = '{en: apply, op: pes_pkg::WR_ADD};
          bump   = 1'b1;
        end
      end
      pes_pkg::REQ_REMOVE: begin
        wr_idx = p_found_idx;
        wr_ctl = '{en: apply && p_flags.found, op: pes_pkg::WR_CLEAR};
      end
      pes_pkg::REQ_FIRE: begin
        wr_idx = p_best_idx;
        wr_due = fire_due;
        if (is_due) begin
          wr_ctl = '{en: apply, op: pes_pkg::WR_FIRE};
          bump   = 1'b1;
        end else begin
          status_next = pes_pkg::STAT_NOT_DUE;
        end
      end
      default: begin
        status_next = pes_pkg::STAT_OK;
      end
    endcase
  end

  // Sequencer next state and strobes
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    accept      = 1'b0;
    start_set   = 1'b0;
    load_p1     = 1'b0;
    load_p2     = 1'b0;
    load_out    = 1'b0;
    apply       = 1'b0;
    case (state)
      pes_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          accept     = 1'b1;
          start_set  = 1'b1;
          state_next = pes_pkg::ST_SCAN1;
        end
      end
      pes_pkg::ST_SCAN1: begin
        if (c_flags[SLOTS].valid) begin
          load_p1    = 1'b1;
          state_next = pes_pkg::ST_APPLY;
        end
      end
      pes_pkg::ST_APPLY: begin
        apply      = 1'b1;
        start_set  = 1'b1;
        state_next = pes_pkg::ST_SCAN2;
      end
      pes_pkg::ST_SCAN2: begin
        if (c_flags[SLOTS].valid) begin
          load_p2    = 1'b1;
          state_next = pes_pkg::ST_DONE;
        end
      end
      pes_pkg::ST_DONE: begin
        if (!out_ch.valid || out_ch.ready) begin
          load_out   = 1'b1;
          state_next = pes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pes_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pes_pkg::ST_IDLE;
      probe_start <= 1'b0;
      counter     <= '0;
    end else begin
      state       <= state_next;
      probe_start <= start_set;
      if (apply && bump) begin
        counter <= counter + 1'b1;
      end
    end
  end

  // Latch the request on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      kind   <= pes_pkg::req_t'(in_ch.req_type);
      key    <= HANDLE_BITS'(in_ch.event_handle);
      period <= in_ch.period_ticks;
      start  <= TIME_BITS'(in_ch.start_time);
      now    <= TIME_BITS'(in_ch.now_time);
    end
  end

  // Capture the tail of the row at the end of each pass
  always_ff @(posedge clk) begin
    if (load_p1) begin
      p_flags       <= c_flags[SLOTS];
      p_found_idx   <= c_found[SLOTS];
      p_free_idx    <= c_free[SLOTS];
      p_best_idx    <= c_bidx[SLOTS];
      p_best_due    <= c_bdue[SLOTS];
      p_best_handle <= c_bhandle[SLOTS];
      p_best_period <= c_bperiod[SLOTS];
    end
    if (apply) begin
      status_r <= status_next;
      fired    <= (kind == pes_pkg::REQ_FIRE && is_due) ? p_best_handle : '0;
    end
    if (load_p2) begin
      r_has_best <= c_flags[SLOTS].has_best;
      r_due      <= c_bdue[SLOTS];
      r_count    <= c_count[SLOTS];
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.status        <= status_r;
      out_ch.due_handle    <= pes_pkg::HANDLE_W'(fired);
      out_ch.next_due_time <= r_has_best ? pes_pkg::TIME_W'(r_due) : {pes_pkg::TIME_W{1'b1}};
      out_ch.live_count    <= pes_pkg::COUNT_W'(r_count);
    end
  end

endmodule

[sv/pes_checker.sv]
// Port-level assertions for the periodic event scheduler, bound to the top.
// Depends on pes_pkg for status codes and field widths.
module pes_port_checker #(
  parameter int SLOTS = pes_pkg::SLOTS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pes_pkg::STATUS_W-1:0] out_status,
  input logic [pes_pkg::HANDLE_W-1:0] out_due_handle,
  input logic [pes_pkg::TIME_W-1:0]   out_next_due_time,
  input logic [pes_pkg::COUNT_W-1:0]  out_live_count
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // The live count never exceeds the table
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (SLOTS < 32) |-> (out_live_count <= SLOTS))
    else $error("live count beyond table size");

  // Only a successful operation reports a handle
  a_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != pes_pkg::STAT_OK) |-> (out_due_handle == '0))
    else $error("handle reported on failed request");

  // An empty table reports no due time
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (SLOTS < 32) && (out_live_count == '0) |->
      (out_next_due_time == {pes_pkg::TIME_W{1'b1}}))
    else $error("due time reported for empty table");

  // No new request is taken while a request is being worked on
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind periodic_event_scheduler pes_port_checker #(.SLOTS(SLOTS)) u_pes_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_due_handle(out_ch.due_handle),
  .out_next_due_time(out_ch.next_due_time), .out_live_count(out_ch.live_count)
);
